// ===== src/iffci_pkg.sv =====
// ----------------------------------------------------------------------------
// iffci_pkg
// shared types and constants for the iff chunk indexer
// ----------------------------------------------------------------------------
`default_nettype none

package iffci_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_LENGTH = 3'd1,
    PH_FTYPE  = 3'd2,
    PH_CTYPE  = 3'd3,
    PH_CSIZE  = 3'd4,
    PH_SKIP   = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHUNK   = 2'd0,
    KIND_NOT_IFF = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_size;
  } result_t;

  // "FORM", first byte first
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h46;
      2'd1: b = 8'h4F;
      2'd2: b = 8'h52;
      2'd3: b = 8'h4D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/iffci_parser.sv =====
// ----------------------------------------------------------------------------
// iffci_parser
// parse state and the per-byte step: header fields, chunk skipping, results
// ----------------------------------------------------------------------------
`default_nettype none

module iffci_parser
  import iffci_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       restart_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [31:0] pos_q, pos_d, cur_pos, pos_inc;
  logic [31:0] shift_q, shift_d, cur_shift, shift_next;
  logic [1:0]  fbc_q, fbc_d, cur_fbc, fbc_inc;
  logic [31:0] flen_q, flen_d, cur_flen;
  logic [32:0] skip_q, skip_d, cur_skip, skip_dec;
  logic        mok_q, mok_d, cur_mok, mok_next;
  logic        last_byte;

  always_comb begin
    // restart clears the parse before this byte is taken as byte 0
    if (restart_i) begin
      cur_phase = PH_MAGIC;
      cur_pos   = '0;
      cur_shift = '0;
      cur_fbc   = '0;
      cur_flen  = '0;
      cur_skip  = '0;
      cur_mok   = 1'b1;
    end else begin
      cur_phase = phase_q;
      cur_pos   = pos_q;
      cur_shift = shift_q;
      cur_fbc   = fbc_q;
      cur_flen  = flen_q;
      cur_skip  = skip_q;
      cur_mok   = mok_q;
    end
  end

  assign pos_inc    = cur_pos + 32'd1;
  assign shift_next = {cur_shift[23:0], byte_i};
  assign fbc_inc    = cur_fbc + 2'd1;
  assign last_byte  = (cur_fbc == 2'd3);
  assign mok_next   = cur_mok & (byte_i == magic_byte(cur_fbc));
  assign skip_dec   = (cur_skip != '0) ? cur_skip - 33'd1 : cur_skip;

  always_comb begin
    phase_d     = cur_phase;
    pos_d       = cur_pos;
    shift_d     = cur_shift;
    fbc_d       = cur_fbc;
    flen_d      = cur_flen;
    skip_d      = cur_skip;
    mok_d       = cur_mok;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_CHUNK, chunk_offset: '0, chunk_size: '0};

    if (cur_phase != PH_DONE) begin
      pos_d = pos_inc;
    end

    // the field counter only runs in the four-byte field phases
    if (cur_phase != PH_DONE && cur_phase != PH_SKIP) begin
      fbc_d = last_byte ? 2'd0 : fbc_inc;
    end

    unique case (cur_phase)
      PH_MAGIC: begin
        mok_d = mok_next;
        if (last_byte) begin
          if (!mok_next) begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_NOT_IFF;
          end else begin
            phase_d = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        shift_d = shift_next;
        if (last_byte) begin
          flen_d  = shift_next;
          shift_d = '0;
          phase_d = PH_FTYPE;
        end
      end
      PH_FTYPE: begin
        if (last_byte) begin
          if (pos_inc < cur_flen) begin
            phase_d = PH_CTYPE;
          end else begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_END;
          end
        end
      end
      PH_CTYPE: begin
        if (last_byte) begin
          shift_d = '0;
          phase_d = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        shift_d = shift_next;
        if (last_byte) begin
          shift_d     = '0;
          res_valid_o = 1'b1;
          // zero size or a wrapped data offset ends the index
          if (shift_next == '0 || pos_inc == '0) begin
            phase_d    = PH_DONE;
            res_o.kind = KIND_END;
          end else begin
            skip_d             = {1'b0, shift_next} + {32'd0, shift_next[0]};
            phase_d            = PH_SKIP;
            res_o.kind         = KIND_CHUNK;
            res_o.chunk_offset = pos_inc;
            res_o.chunk_size   = shift_next;
          end
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          if (pos_inc < cur_flen) begin
            phase_d = PH_CTYPE;
          end else begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_END;
          end
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      pos_q   <= '0;
      shift_q <= '0;
      fbc_q   <= '0;
      flen_q  <= '0;
      skip_q  <= '0;
      mok_q   <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      fbc_q   <= fbc_d;
      flen_q  <= flen_d;
      skip_q  <= skip_d;
      mok_q   <= mok_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/iffci_out_reg.sv =====
// ----------------------------------------------------------------------------
// iffci_out_reg
// result register holding one beat until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module iffci_out_reg
  import iffci_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_valid_i,
  input  wire result_t load_res_i,
  input  wire logic    stall_i,
  output logic         ready_o,
  output logic         valid_o,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  // free when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_valid_i) begin
      res_q <= load_res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== src/iff_chunk_indexer_unit.sv =====
// ----------------------------------------------------------------------------
// iff_chunk_indexer_unit
// indexes the chunks of an iff form stream, one byte per beat
// ----------------------------------------------------------------------------
// Takes one file byte per clock while not stalled, restart_i marking byte 0
// of a new file. A byte is registered on entry, parsed from there, and any
// result it causes (chunk entry, not-iff, end of index) is loaded into the
// result register when its parse step is taken. Throughput is one byte per
// cycle, set by the single parse step between the input and result
// registers; stall on the output holds the pipe and backs up to in_stall_o.
// After not-iff or end of index, bytes are dropped until restart.
`default_nettype none

module iff_chunk_indexer_unit
  import iffci_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      chunk_offset_o,
  output logic [31:0]      chunk_size_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       restart_q;
  logic       out_ready;
  logic       step;
  logic       in_accept;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q    <= byte_in_i;
      restart_q <= restart_i;
    end
  end

  iffci_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .restart_i   (restart_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  iffci_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (step && res_valid),
    .load_res_i   (res),
    .stall_i      (out_stall_i),
    .ready_o      (out_ready),
    .valid_o      (out_valid_o),
    .res_o        (out_res)
  );

  assign kind_o         = out_res.kind;
  assign chunk_offset_o = out_res.chunk_offset;
  assign chunk_size_o   = out_res.chunk_size;

endmodule

`default_nettype wire
